FILE: design/swss_pkg.sv
// Shared constants and types for the sliding-window seen set.
// Used by sliding_window_seen_set; no dependencies of its own.
package swss_pkg;

	// Window size in bits; a power of two between 16 and 65536
	localparam int unsigned WINDOW_BITS = 1024;
	localparam int unsigned RING_BYTES  = WINDOW_BITS / 8;
	localparam int unsigned IDX_W       = $clog2(RING_BYTES);
	localparam int unsigned OFS_W       = $clog2(WINDOW_BITS);
	localparam int unsigned VALUE_W     = 64;

	localparam logic [7:0]         FULL_BYTE = 8'hFF;
	localparam logic [VALUE_W-1:0] BASE_STEP = 64'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_READ,
		ST_SCAN,
		ST_CHECK,
		ST_EMIT
	} state_t;

endpackage

FILE: design/sliding_window_seen_set.sv
// A value below the base or beyond the window is resolved in the compare state; a value
// inside the window is read from the bitmap and marked, and when that fills the head byte
// the window advances, clearing each further full head byte in the scan and check states.
// A new value is accepted only in the idle state, once the previous result is emitted;
// one value is handled at a time, sharing the single 64-bit adder between compare and advance.
// Reset clears base, ring head and the per-byte valid flags at once; no sweep is needed.
module sliding_window_seen_set (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [swss_pkg::VALUE_W-1:0] value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         already_seen,
	output logic                         out_of_range
);

	localparam int unsigned IDX_W   = swss_pkg::IDX_W;
	localparam int unsigned OFS_W   = swss_pkg::OFS_W;
	localparam int unsigned VALUE_W = swss_pkg::VALUE_W;
	localparam logic [IDX_W:0] CLEAR_MAX = (IDX_W+1)'(swss_pkg::RING_BYTES);

	swss_pkg::state_t state_q, state_d;

	logic [VALUE_W-1:0]              value_q;
	logic [VALUE_W-1:0]              base_q;
	logic [IDX_W-1:0]                head_q;
	logic [IDX_W-1:0]                addr_q;
	logic [2:0]                      bit_q;
	logic [IDX_W:0]                  cleared_q;
	logic                            res_seen_q;
	logic                            res_oor_q;
	logic [swss_pkg::RING_BYTES-1:0] valid_q;
	logic                            out_valid_q;
	logic                            out_seen_q;
	logic                            out_oor_q;

	// Shared adder: value - base for the compare, base + 8 for the advance
	logic               use_step;
	logic [VALUE_W-1:0] add_a;
	logic [VALUE_W-1:0] add_b;
	logic               add_cin;
	logic [VALUE_W:0]   sum;
	logic [VALUE_W-1:0] diff;
	logic               below;
	logic               beyond;
	logic [IDX_W-1:0]   cmp_addr;

	logic [7:0] rd_byte;
	logic [7:0] cur_byte;
	logic [7:0] new_byte;
	logic       seen_bit;
	logic       flush_now;
	logic       head_full;

	logic             load_in;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic             ram_we;
	logic             set_res;
	logic             res_seen_d;
	logic             res_oor_d;
	logic             take_addr;
	logic             do_advance;
	logic             first_clear;
	logic             emit;

	assign add_a    = use_step ? base_q : value_q;
	assign add_b    = use_step ? ~swss_pkg::BASE_STEP : base_q;
	assign add_cin  = ~use_step;
	assign sum      = {1'b0, add_a} + {1'b0, ~add_b} + {{VALUE_W{1'b0}}, add_cin};
	assign diff     = sum[VALUE_W-1:0];
	assign below    = ~sum[VALUE_W];
	assign beyond   = |diff[VALUE_W-1:OFS_W];
	assign cmp_addr = diff[OFS_W-1:3] + head_q;

	// A byte whose valid flag is clear reads as zero
	assign cur_byte  = valid_q[addr_q] ? rd_byte : 8'h00;
	assign new_byte  = cur_byte | (8'h01 << bit_q);
	assign seen_bit  = cur_byte[bit_q];
	assign flush_now = (addr_q == head_q) && (new_byte == swss_pkg::FULL_BYTE);
	assign head_full = (cur_byte == swss_pkg::FULL_BYTE) && (cleared_q != CLEAR_MAX);

	assign ram_raddr = (state_q == swss_pkg::ST_CMP) ? cmp_addr : head_q;

	swss_ram #(
		.WIDTH(8),
		.DEPTH(swss_pkg::RING_BYTES)
	) u_bitmap (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(addr_q),
		.wr_data(new_byte),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(rd_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		load_in     = 1'b0;
		ram_re      = 1'b0;
		ram_we      = 1'b0;
		set_res     = 1'b0;
		res_seen_d  = 1'b0;
		res_oor_d   = 1'b0;
		take_addr   = 1'b0;
		do_advance  = 1'b0;
		first_clear = 1'b0;
		use_step    = 1'b0;
		emit        = 1'b0;
		case (state_q)
			swss_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					load_in = 1'b1;
					state_d = swss_pkg::ST_CMP;
				end
			end
			swss_pkg::ST_CMP: begin
				if (below) begin
					set_res    = 1'b1;
					res_seen_d = 1'b1;
					state_d    = swss_pkg::ST_EMIT;
				end else if (beyond) begin
					set_res   = 1'b1;
					res_oor_d = 1'b1;
					state_d   = swss_pkg::ST_EMIT;
				end else begin
					ram_re    = 1'b1;
					take_addr = 1'b1;
					state_d   = swss_pkg::ST_READ;
				end
			end
			swss_pkg::ST_READ: begin
				set_res    = 1'b1;
				res_seen_d = seen_bit;
				// A full head byte is dropped rather than written back
				if (flush_now) begin
					do_advance  = 1'b1;
					first_clear = 1'b1;
					use_step    = 1'b1;
					state_d     = swss_pkg::ST_SCAN;
				end else begin
					ram_we  = 1'b1;
					state_d = swss_pkg::ST_EMIT;
				end
			end
			swss_pkg::ST_SCAN: begin
				ram_re  = 1'b1;
				state_d = swss_pkg::ST_CHECK;
			end
			swss_pkg::ST_CHECK: begin
				if (head_full) begin
					do_advance = 1'b1;
					use_step   = 1'b1;
					state_d    = swss_pkg::ST_SCAN;
				end else begin
					state_d = swss_pkg::ST_EMIT;
				end
			end
			swss_pkg::ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit    = 1'b1;
					state_d = swss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swss_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			head_q      <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[addr_q] <= 1'b1;
			end
			if (do_advance) begin
				valid_q[head_q] <= 1'b0;
				base_q          <= diff;
				head_q          <= head_q + IDX_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_in) begin
			value_q <= value;
		end
		if (take_addr) begin
			addr_q <= cmp_addr;
			bit_q  <= diff[2:0];
		end else if (state_q == swss_pkg::ST_SCAN) begin
			addr_q <= head_q;
		end
		if (do_advance) begin
			cleared_q <= first_clear ? (IDX_W+1)'(1) : cleared_q + (IDX_W+1)'(1);
		end
		if (set_res) begin
			res_seen_q <= res_seen_d;
			res_oor_q  <= res_oor_d;
		end
		if (emit) begin
			out_seen_q <= res_seen_q;
			out_oor_q  <= res_oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign already_seen = out_seen_q;
	assign out_of_range = out_oor_q;

	a_base_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		base_q[2:0] == 3'b000)
		else $error("window base lost its byte alignment");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(already_seen && out_of_range))
		else $error("result flagged both seen and out of range");

	a_head_with_base: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q != $past(head_q)) |-> (base_q == $past(base_q) + swss_pkg::BASE_STEP))
		else $error("ring head moved without the base advancing by one byte");

	a_check_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swss_pkg::ST_CHECK) |-> (cleared_q != '0))
		else $error("head scan entered without a cleared byte");

endmodule

FILE: design/swss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependencies.
module swss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for sliding_window_seen_set: directed table, random
// traffic and a multi-byte sweep, checked against a behavioural predictor.
// Depends on swss_pkg and the sliding_window_seen_set RTL (with swss_ram) only.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned CYCLE_LIMIT  = 2_000_000;
	localparam int unsigned RANDOM_ITEMS = 400;
	localparam int unsigned SWEEP_BYTES  = 16;
	localparam int unsigned TAIL_CYCLES  = 20;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned HOLD_AFTER   = 150;
	localparam int unsigned DIR_ROWS     = 18;

	typedef struct packed {
		logic seen;
		logic oor;
	} verdict_t;

	typedef struct packed {
		logic [swss_pkg::VALUE_W-1:0] v;
		logic                         known;
		logic                         seen;
		logic                         oor;
	} dir_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [swss_pkg::VALUE_W-1:0] value;
	logic                         out_valid;
	logic                         out_stall;
	logic                         already_seen;
	logic                         out_of_range;

	// Predictor state
	logic [7:0]                   seen_map [swss_pkg::RING_BYTES];
	logic [swss_pkg::VALUE_W-1:0] win_base;
	int unsigned                  head;

	verdict_t    pending_verdicts [$];
	int unsigned errors;
	int unsigned results_seen;
	bit          sender_calm;

	// Expected rows typed in where they follow directly from reset or the window edges
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{64'd0,                             1'b1, 1'b0, 1'b0},
		'{64'd0,                             1'b1, 1'b1, 1'b0},
		'{64'(swss_pkg::WINDOW_BITS - 1),    1'b1, 1'b0, 1'b0},
		'{64'(swss_pkg::WINDOW_BITS),        1'b1, 1'b0, 1'b1},
		'{64'hFFFF_FFFF_FFFF_FFFF,           1'b1, 1'b0, 1'b1},
		'{64'h8000_0000_0000_0000,           1'b1, 1'b0, 1'b1},
		'{64'd1,                             1'b0, 1'b0, 1'b0},
		'{64'd2,                             1'b0, 1'b0, 1'b0},
		'{64'd3,                             1'b0, 1'b0, 1'b0},
		'{64'd4,                             1'b0, 1'b0, 1'b0},
		'{64'd5,                             1'b0, 1'b0, 1'b0},
		'{64'd6,                             1'b0, 1'b0, 1'b0},
		'{64'd7,                             1'b0, 1'b0, 1'b0},
		'{64'd0,                             1'b1, 1'b1, 1'b0},
		'{64'd7,                             1'b1, 1'b1, 1'b0},
		'{64'(swss_pkg::WINDOW_BITS + 7),    1'b0, 1'b0, 1'b0},
		'{64'(swss_pkg::WINDOW_BITS + 8),    1'b1, 1'b0, 1'b1},
		'{64'(swss_pkg::WINDOW_BITS - 1),    1'b0, 1'b0, 1'b0}
	};

	sliding_window_seen_set u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.already_seen (already_seen),
		.out_of_range (out_of_range)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 94)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Test the value against the window, mark it and slide over full leading bytes
	task automatic replay_verdict(input logic [swss_pkg::VALUE_W-1:0] v, output verdict_t res);
		logic [swss_pkg::VALUE_W-1:0] ofs;
		int unsigned                  bpos;
		int unsigned                  byte_i;
		int unsigned                  bit_i;
		int unsigned                  n;
		res = '0;
		if (v < win_base) begin
			res.seen = 1'b1;
		end else begin
			ofs = v - win_base;
			if (ofs >= 64'(swss_pkg::WINDOW_BITS)) begin
				res.oor = 1'b1;
			end else begin
				bpos   = (ofs[31:0] + head * 8) % swss_pkg::WINDOW_BITS;
				byte_i = bpos / 8;
				bit_i  = bpos % 8;
				res.seen = seen_map[byte_i][bit_i];
				seen_map[byte_i][bit_i] = 1'b1;
				n = 0;
				while (n < swss_pkg::RING_BYTES && seen_map[head] == swss_pkg::FULL_BYTE) begin
					seen_map[head] = 8'h00;
					win_base += swss_pkg::BASE_STEP;
					head = (head + 1) % swss_pkg::RING_BYTES;
					n++;
				end
			end
		end
	endtask

	// Offer one value, entered and left at a falling edge; log its verdict on acceptance
	task automatic offer_value(input logic [swss_pkg::VALUE_W-1:0] v, input logic known,
			input logic k_seen, input logic k_oor);
		int unsigned gap;
		verdict_t    want;
		gap = sender_calm ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall);
		replay_verdict(v, want);
		if (known) begin
			want.seen = k_seen;
			want.oor  = k_oor;
		end
		pending_verdicts.push_back(want);
		@(negedge clk);
	endtask

	function automatic logic [swss_pkg::VALUE_W-1:0] pick_value();
		int unsigned                  r;
		logic [swss_pkg::VALUE_W-1:0] span;
		r = $urandom_range(0, 99);
		if (r < 50)
			return win_base + $urandom_range(0, $urandom_range(0, 3) == 0 ? 255 : 31);
		else if (r < 62)
			return win_base + $urandom_range(0, swss_pkg::WINDOW_BITS - 1);
		else if (r < 72 && win_base != 0) begin
			span = (win_base < 64'd2000) ? win_base : 64'd2000;
			return win_base - $urandom_range(1, span[31:0]);
		end else if (r < 78)
			return win_base + swss_pkg::WINDOW_BITS - $urandom_range(0, 1);
		else if (r < 84)
			return win_base + swss_pkg::WINDOW_BITS + $urandom_range(0, 5000);
		else
			return {$urandom, $urandom};
	endfunction

	// Receiver: random stalls, calm stretches and one long hold-off
	initial begin : receiver
		int unsigned stall_left;
		int unsigned hold_left;
		int unsigned calm_left;
		bit          held;
		stall_left = 0;
		hold_left  = 0;
		calm_left  = 0;
		held       = 1'b0;
		out_stall  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && results_seen >= HOLD_AFTER) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0)
				hold_left--;
			else if (stall_left > 0)
				stall_left--;
			else if (calm_left > 0)
				calm_left--;
			else if ($urandom_range(0, 99) < 3)
				calm_left = $urandom_range(30, 120);
			else
				stall_left = idle_len();
			out_stall <= (hold_left > 0) || (stall_left > 0);
		end
	end

	always @(posedge clk) begin : check_result
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_verdicts.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction: seen=%b oor=%b",
					$time, already_seen, out_of_range);
			end else begin
				want = pending_verdicts.pop_front();
				if (already_seen !== want.seen) begin
					errors++;
					$display("%0t: already_seen mismatch: expected %b, got %b",
						$time, want.seen, already_seen);
				end
				if (out_of_range !== want.oor) begin
					errors++;
					$display("%0t: out_of_range mismatch: expected %b, got %b",
						$time, want.oor, out_of_range);
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		int unsigned                  sent;
		int unsigned                  calm_items;
		int unsigned                  k;
		int unsigned                  j;
		int unsigned                  t;
		int unsigned                  tmp;
		logic [swss_pkg::VALUE_W-1:0] base0;
		int unsigned                  order [SWEEP_BYTES * 8 - 8];

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		value        = '0;
		errors       = 0;
		results_seen = 0;
		sender_calm  = 1'b0;
		calm_items   = 0;
		win_base     = '0;
		head         = 0;
		foreach (seen_map[i])
			seen_map[i] = 8'h00;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			offer_value(dir_rows[i].v, dir_rows[i].known, dir_rows[i].seen, dir_rows[i].oor);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (calm_items > 0)
				calm_items--;
			else if ($urandom_range(0, 39) == 0)
				calm_items = $urandom_range(20, 60);
			sender_calm = (calm_items > 0);
			if ($urandom_range(0, 15) == 0) begin
				// Fill k bytes from the top down so the head byte completes last
				k     = $urandom_range(1, 4);
				base0 = win_base;
				for (j = 8 * k; j > 0; j--)
					offer_value(base0 + j - 1, 1'b0, 1'b0, 1'b0);
				sent += 8 * k;
			end else begin
				offer_value(pick_value(), 1'b0, 1'b0, 1'b0);
				sent++;
			end
		end

		// Drain, then fill the leading bytes of the window with the head byte last
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		sender_calm = 1'b0;
		foreach (order[i])
			order[i] = i + 8;
		for (j = SWEEP_BYTES * 8 - 9; j > 0; j--) begin
			t        = $urandom_range(0, j);
			tmp      = order[j];
			order[j] = order[t];
			order[t] = tmp;
		end
		base0 = win_base;
		foreach (order[i])
			offer_value(base0 + order[i], 1'b0, 1'b0, 1'b0);
		for (j = 0; j < 8; j++)
			offer_value(base0 + j, 1'b0, 1'b0, 1'b0);

		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
